FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker of the pitch and level tracker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define FPL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define FPL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define FPL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/fpl_pkg.sv
// Shared types, register codes and width helpers for the pitch and level tracker.
// No dependencies; every other RTL module refers to it by scoped names.
`timescale 1ns / 1ps

package fpl_pkg;

	localparam int MAX_FRAME_DEF = 32768;
	localparam int SAMPLE_W      = 8;
	localparam int FREQ_W        = 16;
	localparam int VOL_W         = 4;
	localparam int IN_TDATA_W    = 8;
	localparam int OUT_TDATA_W   = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int RATE_W        = 16;
	localparam int FLEN_W        = 16;
	localparam int NOISE_W       = 4;
	localparam int FRAC_SHIFT    = 23;
	localparam int MHZ_W         = 20;
	localparam int ONE_MHZ       = 1000000;
	localparam int MID_POINT     = 128;
	localparam int VOL_MAX       = 15;
	localparam int VOL_SHIFT     = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_RATE  = 2'd0,
		CFG_FRAME_LENGTH = 2'd1,
		CFG_NOISE_FLOOR  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [RATE_W-1:0]  sample_rate_hz;
		logic [FLEN_W-1:0]  frame_length;
		logic [NOISE_W-1:0] noise_floor;
	} fpl_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mul;
		logic div_step;
		logic avg_step;
		logic load_out;
	} fpl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_end;
	} fpl_sts_t;

	// width of a frame length / index / crossing count
	function automatic int len_w(input int max_frame);
		return $clog2(max_frame + 1);
	endfunction

	// width of the deviation sum
	function automatic int sum_w(input int max_frame);
		return $clog2(max_frame * MID_POINT + 1);
	endfunction

	// width of the frequency dividend crossings * rate * 2^23
	function automatic int num_w(input int max_frame);
		return len_w(max_frame) + RATE_W + FRAC_SHIFT;
	endfunction

	// width of the frequency divisor len * 10^6
	function automatic int den_w(input int max_frame);
		return len_w(max_frame) + MHZ_W;
	endfunction

endpackage

FILE: hw/rtl/frame_pitch_level_tracker_core.sv
// Top level of the frame pitch and level tracker: config registers, controller
// and datapath. Depends on fpl_pkg, fpl_cfg, fpl_ctrl and fpl_datapath.
`timescale 1ns / 1ps

// Usage:
// - s_axis carries one unsigned 8-bit sample per transaction; samples are cut into
//   frames of frame_length samples (clamped to 1..MAX_FRAME).
// - At the end of each frame one transaction leaves on m_axis with the
//   oscillator word (bits 15:0) and the 4-bit volume (bits 19:16).
// - The cfg channel writes sample_rate_hz (index 0), frame_length (1) and
//   noise_floor (2); cfg_ready is always high, other indexes are ignored.
//   Write only while no frame result is pending.
// - Samples inside a frame are taken one per cycle.
// - After the last sample of a frame, s_axis_tready stays low through the
//   product step, one restoring-division step per dividend bit, and the load
//   of the result register. The result is valid in the cycle after the load.
// - If the sink stalls, the result waits in the output register and samples of
//   the next frame are still taken; only the load of the next result waits for it.
// - Reset clears the frame accumulators, drops any pending result and restores
//   rate 8000, frame length 400 and noise floor 2.

module frame_pitch_level_tracker_core #(
	parameter int MAX_FRAME = fpl_pkg::MAX_FRAME_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [fpl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] sample
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [fpl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [15:0] freq_word, [19:16] volume
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fpl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	fpl_pkg::fpl_cfg_t cfg;
	fpl_pkg::fpl_cmd_t cmd;
	fpl_pkg::fpl_sts_t sts;

	logic [fpl_pkg::FREQ_W-1:0] freq_word;
	logic [fpl_pkg::VOL_W-1:0]  volume;

	fpl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fpl_ctrl #(
		.MAX_FRAME (MAX_FRAME)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	fpl_datapath #(
		.MAX_FRAME (MAX_FRAME)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (s_axis_tdata[fpl_pkg::SAMPLE_W-1:0]),
		.freq_word (freq_word),
		.volume    (volume)
	);

	// pack result fields, pad to whole bytes
	assign m_axis_tdata = {
		(fpl_pkg::OUT_TDATA_W - fpl_pkg::FREQ_W - fpl_pkg::VOL_W)'(0),
		volume,
		freq_word
	};

endmodule

FILE: hw/rtl/fpl_cfg.sv
// Configuration register file: sample rate, frame length and noise floor.
// Depends on fpl_pkg for register codes and the config struct.
`timescale 1ns / 1ps

module fpl_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fpl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpl_pkg::CFG_DATA_W-1:0] cfg_data,
	output fpl_pkg::fpl_cfg_t              cfg
);

	fpl_pkg::fpl_cfg_t cfg_q;

	// always take a write; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate_hz <= fpl_pkg::RATE_W'(8000);
			cfg_q.frame_length   <= fpl_pkg::FLEN_W'(400);
			cfg_q.noise_floor    <= fpl_pkg::NOISE_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (fpl_pkg::cfg_idx_t'(cfg_index))
				fpl_pkg::CFG_SAMPLE_RATE:  cfg_q.sample_rate_hz <= cfg_data[fpl_pkg::RATE_W-1:0];
				fpl_pkg::CFG_FRAME_LENGTH: cfg_q.frame_length   <= cfg_data[fpl_pkg::FLEN_W-1:0];
				fpl_pkg::CFG_NOISE_FLOOR:  cfg_q.noise_floor    <= cfg_data[fpl_pkg::NOISE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/fpl_ctrl.sv
// Controller: sequences accumulation, the product step, the shared division
// loop and the result register handoff. Depends on fpl_pkg.
`timescale 1ns / 1ps

module fpl_ctrl #(
	parameter int MAX_FRAME = fpl_pkg::MAX_FRAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  fpl_pkg::fpl_sts_t sts,
	output fpl_pkg::fpl_cmd_t cmd
);

	localparam int NUM_W = fpl_pkg::num_w(MAX_FRAME);
	localparam int SUM_W = fpl_pkg::sum_w(MAX_FRAME);
	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign s_axis_tready = (state_q == ST_ACCUM);
	assign m_axis_tvalid = out_valid_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	// decode commands from state
	always_comb begin
		cmd          = '0;
		cmd.accept   = s_axis_tvalid && (state_q == ST_ACCUM);
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.avg_step = (state_q == ST_DIV) && (cnt_q < CNT_W'(SUM_W));
		cmd.load_out = (state_q == ST_FIN) && out_free;
	end

	// state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACCUM: begin
					if (cmd.accept && sts.frame_end) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_ACCUM;
					end
				end
				default: state_q <= ST_ACCUM;
			endcase
		end
	end

endmodule

FILE: hw/rtl/fpl_datapath.sv
// Datapath: frame accumulators, frame snapshot, multipliers, two restoring
// dividers stepped by the controller, and the result register. Depends on fpl_pkg.
`timescale 1ns / 1ps

module fpl_datapath #(
	parameter int MAX_FRAME = fpl_pkg::MAX_FRAME_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fpl_pkg::fpl_cfg_t               cfg,
	input  fpl_pkg::fpl_cmd_t               cmd,
	output fpl_pkg::fpl_sts_t               sts,
	input  logic [fpl_pkg::SAMPLE_W-1:0]    sample,
	output logic [fpl_pkg::FREQ_W-1:0]      freq_word,
	output logic [fpl_pkg::VOL_W-1:0]       volume
);

	localparam int LEN_W = fpl_pkg::len_w(MAX_FRAME);
	localparam int SUM_W = fpl_pkg::sum_w(MAX_FRAME);
	localparam int NUM_W = fpl_pkg::num_w(MAX_FRAME);
	localparam int DEN_W = fpl_pkg::den_w(MAX_FRAME);
	localparam int PRD_W = LEN_W + fpl_pkg::RATE_W;
	localparam int VPR_W = SUM_W + fpl_pkg::VOL_W;

	// frame accumulators
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] cross_q;
	logic [SUM_W-1:0] sum_q;
	logic             prev_sign_q;

	// division operands
	logic [LEN_W-1:0] cross_snap_q;
	logic [LEN_W-1:0] len_snap_q;
	logic [SUM_W-1:0] avg_q;
	logic [LEN_W-1:0] arem_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;

	logic [fpl_pkg::FREQ_W-1:0] freq_q;
	logic [fpl_pkg::VOL_W-1:0]  vol_q;

	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] idx_nxt;
	logic [LEN_W-1:0] cross_nxt;
	logic [SUM_W-1:0] sum_nxt;
	logic [7:0]       dev;
	logic             sign;
	logic [LEN_W:0]   ashift;
	logic [DEN_W:0]   rshift;
	logic [PRD_W-1:0] prod;
	logic [VPR_W-1:0] vol_prod;
	logic [VPR_W-1:0] vol_raw;
	logic [fpl_pkg::VOL_W-1:0]  vol_sat;
	logic [fpl_pkg::FREQ_W-1:0] freq_sat;

	// clamp the frame length to 1..MAX_FRAME
	always_comb begin
		if (cfg.frame_length == '0) begin
			len = LEN_W'(1);
		end else if ({1'b0, cfg.frame_length} > 17'(MAX_FRAME)) begin
			len = LEN_W'(MAX_FRAME);
		end else begin
			len = LEN_W'(cfg.frame_length);
		end
	end

	// per-sample update
	assign sign      = sample[fpl_pkg::SAMPLE_W-1];
	assign dev       = sign ? (sample - 8'(fpl_pkg::MID_POINT))
	                        : (8'(fpl_pkg::MID_POINT) - sample);
	assign idx_nxt   = idx_q + LEN_W'(1);
	assign cross_nxt = cross_q + LEN_W'((idx_q != '0) && (sign != prev_sign_q));
	assign sum_nxt   = sum_q + SUM_W'(dev);
	assign sts.frame_end = (idx_nxt >= len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cross_q     <= '0;
			sum_q       <= '0;
			prev_sign_q <= 1'b0;
		end else if (cmd.accept) begin
			prev_sign_q <= sign;
			if (sts.frame_end) begin
				idx_q   <= '0;
				cross_q <= '0;
				sum_q   <= '0;
			end else begin
				idx_q   <= idx_nxt;
				cross_q <= cross_nxt;
				sum_q   <= sum_nxt;
			end
		end
	end

	// one restoring step each for the mean and the frequency quotient
	assign ashift = {arem_q, avg_q[SUM_W-1]};
	assign rshift = {rem_q, num_q[NUM_W-1]};
	assign prod   = PRD_W'(cross_snap_q) * PRD_W'(cfg.sample_rate_hz);

	always_ff @(posedge clk) begin
		// snapshot the finished frame
		if (cmd.accept && sts.frame_end) begin
			cross_snap_q <= cross_nxt;
			len_snap_q   <= len;
			avg_q        <= sum_nxt;
			arem_q       <= '0;
		end
		// form the frequency dividend and divisor
		if (cmd.mul) begin
			num_q <= {prod, fpl_pkg::FRAC_SHIFT'(0)};
			den_q <= DEN_W'(len_snap_q) * DEN_W'(fpl_pkg::ONE_MHZ);
			rem_q <= '0;
		end
		if (cmd.avg_step) begin
			if (ashift >= {1'b0, len_snap_q}) begin
				arem_q <= LEN_W'(ashift - {1'b0, len_snap_q});
				avg_q  <= {avg_q[SUM_W-2:0], 1'b1};
			end else begin
				arem_q <= ashift[LEN_W-1:0];
				avg_q  <= {avg_q[SUM_W-2:0], 1'b0};
			end
		end
		if (cmd.div_step) begin
			if (rshift >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(rshift - {1'b0, den_q});
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rshift[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			freq_q <= freq_sat;
			vol_q  <= vol_sat;
		end
	end

	// scale the mean, saturate, and apply the noise floor
	assign vol_prod = VPR_W'(avg_q) * VPR_W'(fpl_pkg::VOL_MAX);
	assign vol_raw  = vol_prod >> fpl_pkg::VOL_SHIFT;

	always_comb begin
		if (vol_raw > VPR_W'(fpl_pkg::VOL_MAX)) begin
			vol_sat = fpl_pkg::VOL_W'(fpl_pkg::VOL_MAX);
		end else begin
			vol_sat = vol_raw[fpl_pkg::VOL_W-1:0];
		end
		if (|num_q[NUM_W-1:fpl_pkg::FREQ_W]) begin
			freq_sat = '1;
		end else begin
			freq_sat = num_q[fpl_pkg::FREQ_W-1:0];
		end
		if (vol_sat < cfg.noise_floor) begin
			vol_sat  = '0;
			freq_sat = '0;
		end
	end

	assign freq_word = freq_q;
	assign volume    = vol_q;

endmodule

FILE: hw/rtl/fpl_checker.sv
// Port-level checks for the pitch and level tracker, bound to the top level.
// Depends on fpl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [fpl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [fpl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [fpl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [fpl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// a stalled result holds
	`FPL_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// a new result only appears after the input side was closed for the division
	`FPL_ASSERT_IMP(a_result_after_div, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without division phase")

	// padding bits above the volume stay zero
	`FPL_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[fpl_pkg::OUT_TDATA_W-1:fpl_pkg::FREQ_W+fpl_pkg::VOL_W] == '0, "nonzero padding in result")

	// config channel never back-pressures
	`FPL_ASSERT(a_cfg_ready, cfg_ready, "config channel not ready")

endmodule

bind frame_pitch_level_tracker_core fpl_checker u_fpl_checker (.*);
